>>> design/assert_macros.svh
// assertion macros shared by the brake core
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ddeb_pkg.sv
// types and constants for the door drift electronic brake
// no dependencies
package ddeb_pkg;

  typedef struct packed {
    logic [15:0] door_position;
    logic [15:0] door_speed;
    logic        motor_stopped;
    logic [15:0] motor_stop_ticks;
    logic        moving_close_fb;
    logic        moving_open_fb;
  } in_item_t;

  typedef struct packed {
    logic              brake_event;
    logic              brake_active;
    logic              duty_valid;
    logic signed [7:0] duty_percent;
    logic              dir_cmd_valid;
    logic              dir_cmd_close;
    logic              stop_motor;
  } out_item_t;

  typedef struct packed {
    logic        brake_feature_on;
    logic [15:0] window_upper;
    logic [15:0] window_lower;
    logic [15:0] sample_interval;
    logic [15:0] stop_window_ticks;
    logic [6:0]  drift_threshold;
    logic [15:0] speed_threshold;
    logic [15:0] brake_timeout;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        tick_count;
    logic [15:0]        previous_position;
    logic signed [15:0] drift_count;
    logic               drift_direction_close;
    logic               braking_enabled;
    logic signed [7:0]  duty_value;
  } brake_state_t;

  localparam int AddrW = 5;

  typedef enum logic [2:0] {
    REG_FEATURE_ON   = 3'd0,
    REG_WINDOW_UPPER = 3'd1,
    REG_WINDOW_LOWER = 3'd2,
    REG_SAMPLE_INT   = 3'd3,
    REG_STOP_WINDOW  = 3'd4,
    REG_DRIFT_THR    = 3'd5,
    REG_SPEED_THR    = 3'd6,
    REG_BRAKE_TMO    = 3'd7
  } reg_idx_t;

  localparam logic signed [7:0]  DutyOnDetect  = -8'sd5;
  localparam logic signed [7:0]  DutyOnTimeout = 8'sd10;
  localparam logic signed [15:0] DriftSatHi    = 16'sh7fff;
  localparam logic signed [15:0] DriftSatLo    = -16'sh8000;

endpackage

>>> design/ddeb_step.sv
// next-state and result logic for one control tick
// depends on ddeb_pkg
module ddeb_step #(
  parameter int DUTY_LIMIT      = 50,
  parameter int DUTY_STEP       = 1,
  parameter int DRIFT_COUNT_MAX = 100
) (
  input  ddeb_pkg::in_item_t     item,
  input  ddeb_pkg::cfg_t         cfg,
  input  ddeb_pkg::brake_state_t st,
  output ddeb_pkg::brake_state_t st_nxt,
  output ddeb_pkg::out_item_t    res
);
  import ddeb_pkg::*;

  localparam logic signed [8:0]  LimHi  = 9'(DUTY_LIMIT);
  localparam logic signed [8:0]  LimLo  = -9'(DUTY_LIMIT);
  localparam logic signed [8:0]  StepW  = 9'(DUTY_STEP);
  localparam logic signed [16:0] CntMax = 17'(DRIFT_COUNT_MAX);

  always_comb begin
    brake_state_t      s;
    logic              ev;
    logic              duty_ok;
    logic              dir_ok;
    logic              dir_close;
    logic              stop;
    logic signed [8:0] dv;
    logic signed [16:0] dc_w;
    logic signed [16:0] thr_w;

    s         = st;
    ev        = 1'b0;
    duty_ok   = 1'b0;
    dir_ok    = 1'b0;
    dir_close = 1'b0;
    stop      = 1'b0;
    dv        = '0;
    dc_w      = '0;
    thr_w     = 17'($unsigned(cfg.drift_threshold));

    // drift check
    if (item.door_position < cfg.window_upper && item.door_position > cfg.window_lower &&
        cfg.brake_feature_on) begin
      if (item.motor_stopped && item.motor_stop_ticks < cfg.stop_window_ticks) begin
        if (s.tick_count >= cfg.sample_interval) begin
          s.tick_count = '0;
          if (s.previous_position > item.door_position) begin
            if (s.drift_count != DriftSatHi) s.drift_count = s.drift_count + 16'sd1;
          end else if (s.previous_position < item.door_position) begin
            if (s.drift_count != DriftSatLo) s.drift_count = s.drift_count - 16'sd1;
          end
          dc_w = 17'(s.drift_count);
          if (dc_w > thr_w) begin
            if (dc_w < CntMax) begin
              s.drift_direction_close = 1'b0;
              s.drift_count           = '0;
              ev                      = 1'b1;
              s.duty_value            = DutyOnDetect;
            end
          end else if (dc_w < -thr_w) begin
            s.drift_direction_close = 1'b1;
            s.drift_count           = '0;
            ev                      = 1'b1;
            s.duty_value            = DutyOnDetect;
          end
          s.previous_position = item.door_position;
        end else begin
          if (s.tick_count == '0) s.previous_position = item.door_position;
          s.tick_count = s.tick_count + 16'd1;
        end
      end else begin
        s.drift_count = 16'sd1;
      end
    end

    // brake control
    if (!item.motor_stopped) begin
      s.braking_enabled = 1'b0;
      s.tick_count      = '0;
    end
    if (s.braking_enabled) begin
      if (item.door_speed > cfg.speed_threshold) begin
        dv = 9'(s.duty_value);
        if (!s.drift_direction_close) begin
          if (item.moving_close_fb) begin
            dir_ok    = 1'b1;
            dir_close = 1'b1;
            dv        = dv - StepW;
          end
        end else begin
          if (item.moving_open_fb) begin
            dir_ok    = 1'b1;
            dir_close = 1'b0;
            dv        = dv - StepW;
          end
        end
        if (dv > LimHi) dv = LimHi;
        if (dv < LimLo) dv = LimLo;
        s.duty_value = dv[7:0];
        duty_ok      = 1'b1;
      end
      if (s.tick_count < cfg.brake_timeout) begin
        s.tick_count = s.tick_count + 16'd1;
      end else begin
        s.tick_count      = '0;
        s.duty_value      = DutyOnTimeout;
        stop              = 1'b1;
        s.braking_enabled = 1'b0;
      end
    end

    if (ev) s.braking_enabled = 1'b1;

    st_nxt            = s;
    res.brake_event   = ev;
    res.brake_active  = s.braking_enabled;
    res.duty_valid    = duty_ok;
    res.duty_percent  = s.duty_value;
    res.dir_cmd_valid = dir_ok;
    res.dir_cmd_close = dir_close;
    res.stop_motor    = stop;
  end

endmodule

>>> design/door_drift_electronic_brake_core.sv
// door drift electronic brake, top level with register port and item pipeline
// depends on ddeb_pkg, ddeb_step and assert_macros.svh
// items pass through the input reg and then the result reg before result valid
// throughput: one item per cycle while out_stall does not hold the output, set by the single-pass step logic
// rst_n is synchronous: clears valids, drift state and loads register defaults
module door_drift_electronic_brake_core #(
  parameter int DUTY_LIMIT      = 50,
  parameter int DUTY_STEP       = 1,
  parameter int DRIFT_COUNT_MAX = 100
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  ddeb_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output ddeb_pkg::out_item_t        out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ddeb_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import ddeb_pkg::*;

  `include "assert_macros.svh"

  cfg_t         cfg_r;
  brake_state_t st_r;
  brake_state_t st_nxt;
  in_item_t     s1_item_r;
  logic         s1_valid_r;
  out_item_t    out_item_r;
  out_item_t    res;
  logic         out_valid_r;
  logic         adv2;
  logic         take_in;
  logic         cfg_wr;
  reg_idx_t     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brake_feature_on  <= 1'b0;
      cfg_r.window_upper      <= 16'd65535;
      cfg_r.window_lower      <= 16'd0;
      cfg_r.sample_interval   <= 16'd10;
      cfg_r.stop_window_ticks <= 16'd100;
      cfg_r.drift_threshold   <= 7'd3;
      cfg_r.speed_threshold   <= 16'd10;
      cfg_r.brake_timeout     <= 16'd200;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FEATURE_ON:   cfg_r.brake_feature_on  <= pwdata[0];
        REG_WINDOW_UPPER: cfg_r.window_upper      <= pwdata[15:0];
        REG_WINDOW_LOWER: cfg_r.window_lower      <= pwdata[15:0];
        REG_SAMPLE_INT:   cfg_r.sample_interval   <= pwdata[15:0];
        REG_STOP_WINDOW:  cfg_r.stop_window_ticks <= pwdata[15:0];
        REG_DRIFT_THR:    cfg_r.drift_threshold   <= pwdata[6:0];
        REG_SPEED_THR:    cfg_r.speed_threshold   <= pwdata[15:0];
        REG_BRAKE_TMO:    cfg_r.brake_timeout     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FEATURE_ON:   prdata = {31'd0, cfg_r.brake_feature_on};
      REG_WINDOW_UPPER: prdata = {16'd0, cfg_r.window_upper};
      REG_WINDOW_LOWER: prdata = {16'd0, cfg_r.window_lower};
      REG_SAMPLE_INT:   prdata = {16'd0, cfg_r.sample_interval};
      REG_STOP_WINDOW:  prdata = {16'd0, cfg_r.stop_window_ticks};
      REG_DRIFT_THR:    prdata = {25'd0, cfg_r.drift_threshold};
      REG_SPEED_THR:    prdata = {16'd0, cfg_r.speed_threshold};
      REG_BRAKE_TMO:    prdata = {16'd0, cfg_r.brake_timeout};
      default:          prdata = '0;
    endcase
  end

  // pipeline control
  assign adv2     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv2;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (take_in) begin
        s1_valid_r <= 1'b1;
      end else if (adv2) begin
        s1_valid_r <= 1'b0;
      end
      if (adv2) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) s1_item_r <= in_item;
    if (adv2) out_item_r <= res;
  end

  ddeb_step #(
    .DUTY_LIMIT      (DUTY_LIMIT),
    .DUTY_STEP       (DUTY_STEP),
    .DRIFT_COUNT_MAX (DRIFT_COUNT_MAX)
  ) u_step (
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_IMPLIES(a_dir_close_needs_valid, out_valid_r && out_item_r.dir_cmd_close, out_item_r.dir_cmd_valid, "dir_cmd_close without dir_cmd_valid")
  `ASSERT_IMPLIES(a_dir_needs_duty, out_valid_r && out_item_r.dir_cmd_valid, out_item_r.duty_valid, "direction command without duty update")
  `ASSERT_IMPLIES(a_stop_duty, out_valid_r && out_item_r.stop_motor, out_item_r.duty_percent == DutyOnTimeout, "timeout duty not applied")
  `ASSERT_IMPLIES(a_event_arms, out_valid_r && out_item_r.brake_event, out_item_r.brake_active, "brake event without braking armed")
  `ASSERT_NEXT(a_s1_held, s1_valid_r && !adv2, s1_valid_r, "held item dropped from input stage")

endmodule
